FILE: sv/sectioned_xor_link_transfer_unit_macros.svh
// ---------------------------------------------------------------------------
// sectioned xor link transfer unit assertion macros
// shared concurrent assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef SECTIONED_XOR_LINK_TRANSFER_UNIT_MACROS_SVH
`define SECTIONED_XOR_LINK_TRANSFER_UNIT_MACROS_SVH

// same-cycle implication
`define SXL_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SXL_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/sxl_pkg.sv
// ---------------------------------------------------------------------------
// sxl_pkg
// types and link codes for the sectioned xor link transfer unit
// ---------------------------------------------------------------------------
package sxl_pkg;

   localparam int INDEX_W   = 15;
   localparam int WORD_W    = 32;
   localparam int SEC_W     = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [SEC_W-1:0] SEC_MAX = '1;

   localparam logic [WORD_W-1:0] WORD_CONT  = 32'h4742C047;
   localparam logic [WORD_W-1:0] WORD_FAIL  = 32'h4742BAD0;
   localparam logic [WORD_W-1:0] WORD_ABORT = 32'h4742AB0B;
   localparam logic [WORD_W-1:0] WORD_OKOK  = 32'h4F4B4F4B;
   localparam logic [WORD_W-1:0] WORD_BAD   = 32'h4641494C;

   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTIONS  = 2'd1;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_START = 2'd2,
      KIND_XCHG  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      LINK_IDLE  = 2'd0,
      LINK_RUN   = 2'd1,
      LINK_DONE  = 2'd2,
      LINK_ABORT = 2'd3
   } link_type;

   typedef enum logic [1:0] {
      PH_DATA    = 2'd0,
      PH_CHECK   = 2'd1,
      PH_VERDICT = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ARM_KEEP = 2'd0,
      ARM_ZERO = 2'd1,
      ARM_WORD = 2'd2,
      ARM_RAM  = 2'd3
   } arm_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [INDEX_W-1:0] word_index;
      logic [WORD_W-1:0]  load_value;
      logic [WORD_W-1:0]  rx_word;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0] next_tx;
      logic [WORD_W-1:0] read_value;
      logic [1:0]        link_state;
      logic [SEC_W-1:0]  sections_finished;
   } rsp_payload_type;

endpackage

FILE: sv/sxl_ram.sv
// ---------------------------------------------------------------------------
// sxl_ram
// generic simple dual port ram with registered read
// ---------------------------------------------------------------------------
module sxl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sectioned_xor_link_transfer_unit.sv
// ---------------------------------------------------------------------------
// sectioned_xor_link_transfer_unit
// slave side of a sectioned word link with xor32 checksum and verdict words
// ---------------------------------------------------------------------------
// requests enter on req_valid/req_stall with a req_payload: load, read,
// start or one link exchange. every request gives one response on
// rsp_valid/rsp_stall holding the word to arm next, the read word, the link
// state and the finished section count.
// the buffer ram is accessed at acceptance (load, read, stored or sent
// data word), and the cycle after that the control state is updated and
// the next armed word, when it comes from the buffer, is fetched from the
// same ram. the response register then loads once any waiting response
// is taken. no new request is taken while one is in its control update,
// since each request needs two buffer ram accesses.
// the response register lets the next request enter while a response
// waits; if rsp_stall holds the response, the request behind it stays
// inside and req_stall rises until the response is taken.
// direction and section_count are written on csr_valid/csr_ready while no
// request is inside; a request offered in the cycle of a write is stalled
// in that cycle. synchronous reset clears the link to idle; the buffer
// itself is not cleared and requests are taken right after reset.
// ---------------------------------------------------------------------------
module sectioned_xor_link_transfer_unit #(
   parameter int BUFFER_WORDS  = 32768,
   parameter int SECTION_LEN_P = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sxl_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sxl_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sxl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sxl_pkg::SEC_W-1:0]           csr_data
);

   import sxl_pkg::*;

   localparam int ADDR_W   = $clog2(BUFFER_WORDS);
   localparam int WC_W     = (SECTION_LEN_P > 1) ? $clog2(SECTION_LEN_P) : 1;
   localparam int SEC_STEP = SECTION_LEN_P % BUFFER_WORDS;
   localparam int WC_LAST  = SECTION_LEN_P - 1;

   function automatic logic [ADDR_W-1:0] wrap_index(input logic [INDEX_W-1:0] x);
      logic [31:0] r;
      r = 32'(x);
      for (int k = 8; k >= 0; k--) begin
         if (r >= (32'(BUFFER_WORDS) << k)) begin
            r = r - (32'(BUFFER_WORDS) << k);
         end
      end
      return r[ADDR_W-1:0];
   endfunction

   // configuration
   logic             direction_ff;
   logic [SEC_W-1:0] section_count_ff;

   // link state
   phase_type        phase_ff, phase_in;
   logic [WC_W-1:0]  wc_ff, wc_in;
   logic [WORD_W-1:0] xor_ff, xor_in;
   logic [SEC_W-1:0] sec_ff, sec_in;
   logic             ok_ff, ok_in;
   link_type         status_ff, status_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0] armed_ff;

   // request stages
   logic             s1_valid_ff;
   kind_type         s1_kind_ff;
   logic [WORD_W-1:0] s1_rx_ff;
   logic             s2_valid_ff;
   kind_type         s2_kind_ff;
   arm_type          s2_arm_ff, arm_in;
   logic [WORD_W-1:0] s2_word_ff, arm_word_in;

   logic             rsp_valid_ff;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   // ram port
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   logic              req_accept;
   logic              s2_done;
   kind_type          req_kind;
   logic [ADDR_W-1:0] req_index;
   logic              xchg_data;
   logic              fetch;

   logic [WORD_W-1:0] xor_mix;
   logic [SEC_W-1:0]  sec_step;
   logic [ADDR_W:0]   base_sum;
   logic [ADDR_W-1:0] base_step;
   logic [ADDR_W:0]   addr_sum;
   logic [ADDR_W-1:0] addr_step;
   logic              go_finish;
   logic              go_begin;
   logic [SEC_W-1:0]  fin_sec;
   logic [ADDR_W-1:0] fin_base;
   logic [WORD_W-1:0] armed_new;

   // handshakes
   assign s2_done    = s2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff || (s2_valid_ff && rsp_valid_ff && rsp_stall) ||
                       (csr_valid && csr_ready);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = !(s1_valid_ff || s2_valid_ff);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // access at acceptance
   assign req_kind  = kind_type'(req_payload.kind);
   assign req_index = wrap_index(req_payload.word_index);
   assign xchg_data = (req_kind == KIND_XCHG) && (status_ff == LINK_RUN) &&
                      (phase_ff == PH_DATA);

   always_comb begin
      ram_wr_en   = req_accept && ((req_kind == KIND_LOAD) || (xchg_data && direction_ff));
      ram_wr_addr = (req_kind == KIND_LOAD) ? req_index : addr_ff;
      ram_wr_data = (req_kind == KIND_LOAD) ? req_payload.load_value : req_payload.rx_word;
      if (s1_valid_ff) begin
         ram_rd_en   = fetch;
         ram_rd_addr = addr_in;
      end else begin
         ram_rd_en   = req_accept && ((req_kind == KIND_READ) || (xchg_data && !direction_ff));
         ram_rd_addr = (req_kind == KIND_READ) ? req_index : addr_ff;
      end
   end

   sxl_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BUFFER_WORDS)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // link update in the cycle after acceptance
   always_comb begin
      phase_in    = phase_ff;
      wc_in       = wc_ff;
      xor_in      = xor_ff;
      sec_in      = sec_ff;
      ok_in       = ok_ff;
      status_in   = status_ff;
      base_in     = base_ff;
      addr_in     = addr_ff;
      arm_in      = ARM_KEEP;
      arm_word_in = '0;
      fetch       = 1'b0;
      go_finish   = 1'b0;
      go_begin    = 1'b0;
      fin_sec     = sec_ff;
      fin_base    = base_ff;

      xor_mix   = direction_ff ? (xor_ff ^ s1_rx_ff) : (xor_ff ^ ram_rd_data);
      sec_step  = sec_ff + SEC_W'(1);
      base_sum  = {1'b0, base_ff} + (ADDR_W+1)'(SEC_STEP);
      if (sec_ff == SEC_MAX) begin
         base_step = '0;
      end else if (base_sum >= (ADDR_W+1)'(BUFFER_WORDS)) begin
         base_step = ADDR_W'(base_sum - (ADDR_W+1)'(BUFFER_WORDS));
      end else begin
         base_step = base_sum[ADDR_W-1:0];
      end
      addr_sum  = {1'b0, addr_ff} + (ADDR_W+1)'(1);
      addr_step = (addr_sum == (ADDR_W+1)'(BUFFER_WORDS)) ? '0 : addr_sum[ADDR_W-1:0];

      if (s1_valid_ff) begin
         case (s1_kind_ff)
            KIND_START: begin
               sec_in    = '0;
               ok_in     = 1'b0;
               status_in = LINK_RUN;
               base_in   = '0;
               fin_sec   = '0;
               fin_base  = '0;
               go_finish = 1'b1;
            end
            KIND_XCHG: begin
               if (status_ff == LINK_RUN) begin
                  unique case (phase_ff)
                     PH_DATA: begin
                        xor_in = xor_mix;
                        if (!direction_ff && (s1_rx_ff == WORD_ABORT)) begin
                           status_in = LINK_ABORT;
                           arm_in    = ARM_ZERO;
                        end else if (wc_ff == WC_W'(WC_LAST)) begin
                           phase_in    = PH_CHECK;
                           wc_in       = '0;
                           arm_in      = direction_ff ? ARM_ZERO : ARM_WORD;
                           arm_word_in = xor_mix;
                        end else begin
                           wc_in   = wc_ff + WC_W'(1);
                           addr_in = addr_step;
                           if (direction_ff) begin
                              arm_in = ARM_ZERO;
                           end else begin
                              arm_in = ARM_RAM;
                              fetch  = 1'b1;
                           end
                        end
                     end
                     PH_CHECK: begin
                        phase_in = PH_VERDICT;
                        if (direction_ff) begin
                           ok_in       = (s1_rx_ff == xor_ff);
                           arm_in      = ARM_WORD;
                           arm_word_in = (s1_rx_ff == xor_ff) ? WORD_OKOK : WORD_BAD;
                        end else begin
                           arm_in = ARM_ZERO;
                        end
                     end
                     default: begin
                        if (direction_ff) begin
                           if (s1_rx_ff != WORD_CONT) begin
                              status_in = LINK_ABORT;
                              arm_in    = ARM_ZERO;
                           end else begin
                              if (ok_ff) begin
                                 sec_in   = sec_step;
                                 base_in  = base_step;
                                 fin_sec  = sec_step;
                                 fin_base = base_step;
                              end
                              go_finish = 1'b1;
                           end
                        end else if (s1_rx_ff == WORD_CONT) begin
                           sec_in    = sec_step;
                           base_in   = base_step;
                           fin_sec   = sec_step;
                           fin_base  = base_step;
                           go_finish = 1'b1;
                        end else if (s1_rx_ff == WORD_FAIL) begin
                           go_begin = 1'b1;
                        end else begin
                           status_in = LINK_ABORT;
                           arm_in    = ARM_ZERO;
                        end
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase

         if (go_finish) begin
            if (fin_sec >= section_count_ff) begin
               status_in = LINK_DONE;
               arm_in    = ARM_ZERO;
            end else begin
               go_begin = 1'b1;
            end
         end

         if (go_begin) begin
            phase_in = PH_DATA;
            wc_in    = '0;
            xor_in   = '0;
            addr_in  = fin_base;
            if (direction_ff) begin
               arm_in = ARM_ZERO;
            end else begin
               arm_in = ARM_RAM;
               fetch  = 1'b1;
            end
         end
      end
   end

   // response assembly
   always_comb begin
      case (s2_arm_ff)
         ARM_KEEP: armed_new = armed_ff;
         ARM_ZERO: armed_new = '0;
         ARM_WORD: armed_new = s2_word_ff;
         default:  armed_new = ram_rd_data;
      endcase
      rsp_payload_in.next_tx           = (status_ff == LINK_RUN) ? armed_new : '0;
      rsp_payload_in.read_value        = (s2_kind_ff == KIND_READ) ? ram_rd_data : '0;
      rsp_payload_in.link_state        = status_ff;
      rsp_payload_in.sections_finished = sec_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff     <= 1'b0;
         section_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DIRECTION: direction_ff     <= csr_data[0];
            CSR_SECTIONS:  section_count_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // link state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DATA;
         wc_ff     <= '0;
         xor_ff    <= '0;
         sec_ff    <= '0;
         ok_ff     <= 1'b0;
         status_ff <= LINK_IDLE;
         base_ff   <= '0;
         addr_ff   <= '0;
         armed_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         wc_ff     <= wc_in;
         xor_ff    <= xor_in;
         sec_ff    <= sec_in;
         ok_ff     <= ok_in;
         status_ff <= status_in;
         base_ff   <= base_in;
         addr_ff   <= addr_in;
         if (s2_done) begin
            armed_ff <= armed_new;
         end
      end
   end

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         if (s1_valid_ff) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_done) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff <= req_kind;
         s1_rx_ff   <= req_payload.rx_word;
      end
      if (s1_valid_ff) begin
         s2_kind_ff <= s1_kind_ff;
         s2_arm_ff  <= arm_in;
         s2_word_ff <= arm_word_in;
      end
      if (s2_done) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

FILE: sv/sxl_checker.sv
// ---------------------------------------------------------------------------
// sxl_checker
// port level checks for the sectioned xor link transfer unit
// ---------------------------------------------------------------------------
`include "sectioned_xor_link_transfer_unit_macros.svh"

module sxl_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input sxl_pkg::rsp_payload_type rsp_payload
);

   import sxl_pkg::*;

   `SXL_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "response changed while stalled")

   `SXL_ASSERT_NEXT(a_req_gap, req_valid && !req_stall, !(req_valid && !req_stall), "requests accepted on consecutive cycles")

   `SXL_ASSERT_IMPL(a_tx_idle, rsp_valid && (rsp_payload.link_state != LINK_RUN), rsp_payload.next_tx == '0, "armed word nonzero while link not running")

   `SXL_ASSERT_IMPL(a_idle_count, rsp_valid && (rsp_payload.link_state == LINK_IDLE), rsp_payload.sections_finished == '0, "section count nonzero while idle")

endmodule

bind sectioned_xor_link_transfer_unit sxl_checker u_sxl_checker (.*);
